/* rtl/dsk_pkg.sv */
// Shared types and codes for the two-stack shared buffer.
`timescale 1ns / 1ps
`default_nettype none
package dsk_pkg;

  typedef logic [1:0] status_t;

  localparam status_t ST_DONE  = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_PULL = 1'b1;

  localparam logic SIDE_LOW  = 1'b0;
  localparam logic SIDE_HIGH = 1'b1;

  localparam int FIELD_WIDTH = 16;

endpackage
`default_nettype wire

/* rtl/dsk_ram.sv */
// Single-port synchronous slot memory with a registered read.
`timescale 1ns / 1ps
`default_nettype none
module dsk_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

/* rtl/shared_buffer_dual_stack.sv */
// Top level of the two-stack shared buffer: pointer control and result register.
//
// Two LIFO stacks share one memory of CAPACITY slots. The low stack grows
// upward from slot 0 and the high stack grows downward from the last slot.
// A push (in_func = 0) sends an odd in_value to the low stack and an even one
// to the high stack, and is refused with a full status when no slot is free.
// A pull (in_func = 1) pops the stack named by in_pull_side, or the other one
// when that stack is empty, and reports empty when both are.
// A transaction is accepted at a rising edge with start high and busy low.
// Each transaction gives one result in the following cycle, marked by
// out_valid for exactly one cycle; the receiver cannot stall it.
// Result data comes from the registered read of the slot memory.
// One transaction can be accepted in every cycle, so busy stays low: a push
// writes its slot at the accept edge, ahead of any pull accepted next.
// Reset empties both stacks and clears out_valid; slot contents are kept.
`timescale 1ns / 1ps
`default_nettype none
module shared_buffer_dual_stack #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic                            in_func,
  input  wire logic [dsk_pkg::FIELD_WIDTH-1:0] in_value,
  input  wire logic                            in_pull_side,
  output logic                                 out_valid,
  output logic      [dsk_pkg::FIELD_WIDTH-1:0] out_data,
  output dsk_pkg::status_t                     out_status,
  output logic                                 out_popped_side
);
  import dsk_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]         low_cnt_r, low_cnt_nxt;
  logic [CW-1:0]         high_cnt_r, high_cnt_nxt;
  logic                  valid_r;
  status_t               status_r, status_nxt;
  logic                  side_r, side_nxt;
  logic                  pop_r, pop_nxt;

  logic                  accept;
  logic                  full;
  logic                  pop_low;
  logic                  pop_high;
  logic                  ram_en;
  logic                  ram_we;
  logic [CW-1:0]         addr_full;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic [DATA_WIDTH-1:0] ram_rdata;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = ({1'b0, low_cnt_r} + {1'b0, high_cnt_r}) >= (CW + 1)'(CAPACITY);

  always_comb begin
    if (in_pull_side == SIDE_LOW) begin
      pop_low  = (low_cnt_r != '0);
      pop_high = (low_cnt_r == '0) && (high_cnt_r != '0);
    end else begin
      pop_high = (high_cnt_r != '0);
      pop_low  = (high_cnt_r == '0) && (low_cnt_r != '0);
    end
  end

  always_comb begin
    low_cnt_nxt  = low_cnt_r;
    high_cnt_nxt = high_cnt_r;
    status_nxt   = ST_DONE;
    side_nxt     = SIDE_LOW;
    pop_nxt      = 1'b0;
    ram_en       = 1'b0;
    ram_we       = 1'b0;
    addr_full    = '0;
    if (accept) begin
      unique case (in_func)
        FUNC_PUSH: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else if (in_value[0]) begin
            ram_en      = 1'b1;
            ram_we      = 1'b1;
            addr_full   = low_cnt_r;
            low_cnt_nxt = low_cnt_r + 1'b1;
          end else begin
            ram_en       = 1'b1;
            ram_we       = 1'b1;
            addr_full    = CW'(CAPACITY - 1) - high_cnt_r;
            high_cnt_nxt = high_cnt_r + 1'b1;
          end
        end
        FUNC_PULL: begin
          if (pop_low) begin
            ram_en      = 1'b1;
            addr_full   = low_cnt_r - 1'b1;
            low_cnt_nxt = low_cnt_r - 1'b1;
            pop_nxt     = 1'b1;
            side_nxt    = SIDE_LOW;
          end else if (pop_high) begin
            ram_en       = 1'b1;
            addr_full    = CW'(CAPACITY) - high_cnt_r;
            high_cnt_nxt = high_cnt_r - 1'b1;
            pop_nxt      = 1'b1;
            side_nxt     = SIDE_HIGH;
          end else begin
            status_nxt = ST_EMPTY;
          end
        end
        default: begin
          status_nxt = ST_DONE;
        end
      endcase
    end
  end

  assign ram_wdata = DATA_WIDTH'(in_value);

  dsk_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_WIDTH)
  ) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (addr_full[AW-1:0]),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_cnt_r  <= '0;
      high_cnt_r <= '0;
      valid_r    <= 1'b0;
      status_r   <= ST_DONE;
      side_r     <= SIDE_LOW;
      pop_r      <= 1'b0;
    end else begin
      low_cnt_r  <= low_cnt_nxt;
      high_cnt_r <= high_cnt_nxt;
      valid_r    <= accept;
      status_r   <= status_nxt;
      side_r     <= side_nxt;
      pop_r      <= pop_nxt;
    end
  end

  assign out_valid       = valid_r;
  assign out_status      = status_r;
  assign out_popped_side = side_r;
  assign out_data        = pop_r ? FIELD_WIDTH'(ram_rdata) : '0;

endmodule
`default_nettype wire

/* rtl/dsk_checker.sv */
// Port-level checks of the two-stack shared buffer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module dsk_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            start,
  input wire logic                            busy,
  input wire logic                            out_valid,
  input wire logic [dsk_pkg::FIELD_WIDTH-1:0] out_data,
  input wire dsk_pkg::status_t                out_status,
  input wire logic                            out_popped_side
);
  import dsk_pkg::*;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("A transaction gave no result in the next cycle.");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |=> !out_valid)
    else $error("A result appeared without a transaction.");

  a_fail_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_DONE) |-> (out_data == '0))
    else $error("A refused transaction returned nonzero data.");

  a_empty_side: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_EMPTY) |-> (out_popped_side == SIDE_LOW))
    else $error("An empty pull reported the high stack.");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_DONE || out_status == ST_EMPTY ||
                   out_status == ST_FULL))
    else $error("Result status holds an undefined code.");

endmodule

bind shared_buffer_dual_stack dsk_checker u_dsk_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_data        (out_data),
  .out_status      (out_status),
  .out_popped_side (out_popped_side)
);
`default_nettype wire
